[sv/pn9dw_pkg.sv]
// ----------------------------------------------------------------------------
// pn9dw_pkg
// Shared types and constants for the PN9 packet de-whitener.
// ----------------------------------------------------------------------------
`default_nettype none

package pn9dw_pkg;

    localparam int HEADER_W      = 16;
    localparam int PAYLOAD_W     = 14;
    localparam int PN9_W         = 9;
    localparam int BYTES_W       = 11;
    localparam int MAX_BYTES_W   = 13;

    localparam int MAX_PACKET_BYTES_DEF = 2047;

    localparam logic [HEADER_W-1:0]  HDR_LEN_RESET = 16'd16;
    localparam logic [PN9_W-1:0]     PN9_INIT      = 9'h1ff;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX   = 14'h3fff;

    // One received bit with its packet tag
    typedef struct packed {
        logic               in_bit;
        logic               packet_start;
        logic [BYTES_W-1:0] packet_bytes;
    } t_in_item;

    // One output bit and its whitening flag
    typedef struct packed {
        logic out_bit;
        logic whitened;
    } t_out_item;

endpackage

`default_nettype wire

[sv/pn9dw_core.sv]
// ----------------------------------------------------------------------------
// pn9dw_core
// Packet state: header and payload bit counters, PN9 register and the
// header length register. Produces the result for the current transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pn9dw_core
    import pn9dw_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [HEADER_W-1:0] i_cfg_data,
    input  wire logic          i_accept,
    input  wire t_in_item      i_item,
    output t_out_item          o_result
);

    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES = MAX_BYTES_W'(MAX_PACKET_BYTES);

    logic [HEADER_W-1:0]  r_hdr_len;
    logic [HEADER_W-1:0]  r_header_left, n_header_left;
    logic [PAYLOAD_W-1:0] r_payload_left, n_payload_left;
    logic [PN9_W-1:0]     r_pn9, n_pn9;

    logic [BYTES_W-1:0]   bytes_clamped;
    logic [PAYLOAD_W-1:0] total_bits;
    logic [HEADER_W:0]    total_ext;
    logic [HEADER_W:0]    hdr_ext;
    logic [HEADER_W:0]    diff;
    logic [PAYLOAD_W-1:0] payload_load;
    logic                 pn9_new;

    // Payload length of a new packet: 8 * bytes minus header, saturated
    always_comb begin
        if ({{(MAX_BYTES_W-BYTES_W){1'b0}}, i_item.packet_bytes} > MAX_BYTES) begin
            bytes_clamped = MAX_BYTES[BYTES_W-1:0];
        end else begin
            bytes_clamped = i_item.packet_bytes;
        end
        total_bits = {bytes_clamped, 3'b000};
        total_ext  = {{(HEADER_W+1-PAYLOAD_W){1'b0}}, total_bits};
        hdr_ext    = {1'b0, r_hdr_len};
        diff       = total_ext - hdr_ext;
        if (total_ext > hdr_ext) begin
            if (diff > {{(HEADER_W+1-PAYLOAD_W){1'b0}}, PAYLOAD_MAX}) begin
                payload_load = PAYLOAD_MAX;
            end else begin
                payload_load = diff[PAYLOAD_W-1:0];
            end
        end else begin
            payload_load = '0;
        end
    end

    assign pn9_new = r_pn9[8] ^ r_pn9[3];

    // Next state and result of one transaction
    always_comb begin
        n_header_left     = r_header_left;
        n_payload_left    = r_payload_left;
        n_pn9             = r_pn9;
        o_result.out_bit  = i_item.in_bit;
        o_result.whitened = 1'b0;
        if (r_header_left != '0) begin
            n_header_left = r_header_left - 1'b1;
        end else if (r_payload_left != '0) begin
            n_pn9             = {r_pn9[PN9_W-2:0], pn9_new};
            o_result.out_bit  = i_item.in_bit ^ pn9_new;
            o_result.whitened = 1'b1;
            n_payload_left    = r_payload_left - 1'b1;
        end else if (i_item.packet_start) begin
            // Start bit counts as the first header bit
            n_header_left  = (r_hdr_len != '0) ? r_hdr_len - 1'b1 : '0;
            n_payload_left = payload_load;
            n_pn9          = PN9_INIT;
        end
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len <= HDR_LEN_RESET;
        end else if (i_cfg_we) begin
            r_hdr_len <= i_cfg_data;
        end
    end

    // Advance packet state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_left  <= '0;
            r_payload_left <= '0;
            r_pn9          <= '0;
        end else if (i_accept) begin
            r_header_left  <= n_header_left;
            r_payload_left <= n_payload_left;
            r_pn9          <= n_pn9;
        end
    end

endmodule

`default_nettype wire

[sv/pn9dw_outreg.sv]
// ----------------------------------------------------------------------------
// pn9dw_outreg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module pn9dw_outreg
    import pn9dw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_result,
    input  wire logic      i_out_stall,
    output logic           o_full_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    logic      r_valid, n_valid;
    t_out_item r_data;

    // Stall upstream only when a result waits and the consumer holds it
    assign o_full_stall = r_valid & i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on each new transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

[sv/pn9_packet_dewhitener.sv]
// Latency: a result is valid on the cycle after its input transaction is accepted.
// Throughput: one bit per cycle while not stalled; counters and PN9 step update on acceptance.
// Input is stalled only while a finished result waits and the output is stalled.
// Synchronous active-low reset clears counters, PN9 register and output valid,
// and loads the header length register with 16. The config port is always ready.
// ----------------------------------------------------------------------------
// pn9_packet_dewhitener
// PN9 de-whitener for a bit stream with tagged packet starts.
// ----------------------------------------------------------------------------
`default_nettype none

module pn9_packet_dewhitener
    import pn9dw_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [HEADER_W-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_item            i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_item                o_out_data
);

    logic      in_accept;
    t_out_item result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid & ~o_in_stall;

    pn9dw_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_valid & o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_accept  (in_accept),
        .i_item    (i_in_data),
        .o_result  (result)
    );

    pn9dw_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_full_stall(o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[sv/pn9dw_checker.sv]
// ----------------------------------------------------------------------------
// pn9dw_checker
// Port-level checks for the PN9 de-whitener, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pn9dw_checker
    import pn9dw_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire t_out_item           o_out_data
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Every accepted transaction yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted bit produced no result");

    // Input stalls only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind pn9_packet_dewhitener pn9dw_checker u_pn9dw_checker (.*);

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pn9_packet_dewhitener: tagged packets with random
// content, header lengths and handshake gaps, each output bit checked against
// a bit-exact PN9 de-whitening predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pn9dw_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 5;

    // Predict each output bit and compare it with what the block returns
    class pn9_bit_checker;
        logic [HEADER_W-1:0]  hdr_len;
        logic [HEADER_W-1:0]  header_left;
        logic [PAYLOAD_W-1:0] payload_left;
        logic [PN9_W-1:0]     pn9_state;
        t_out_item            expected_bits[$];
        int                   errors;

        function new();
            hdr_len      = HDR_LEN_RESET;
            header_left  = '0;
            payload_left = '0;
            pn9_state    = '0;
            errors       = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("tb: %0t: %s", $time, msg);
            end
        endfunction

        // Advance the packet state by one accepted input bit
        function void predict_bit(t_in_item it);
            t_out_item   r;
            logic        nb;
            int unsigned nbytes;
            int unsigned total;
            r.out_bit  = it.in_bit;
            r.whitened = 1'b0;
            if (header_left != 0) begin
                header_left--;
            end else if (payload_left != 0) begin
                nb         = pn9_state[8] ^ pn9_state[3];
                pn9_state  = {pn9_state[PN9_W-2:0], nb};
                r.out_bit  = it.in_bit ^ nb;
                r.whitened = 1'b1;
                payload_left--;
            end else begin
                // Load counts and seed only on a start seen while idle
                if (it.packet_start) begin
                    nbytes = it.packet_bytes;
                    if (nbytes > MAX_PACKET_BYTES_DEF) begin
                        nbytes = MAX_PACKET_BYTES_DEF;
                    end
                    total       = 8 * nbytes;
                    header_left = hdr_len;
                    if (total > hdr_len) begin
                        total = total - hdr_len;
                        payload_left = (total > PAYLOAD_MAX) ? PAYLOAD_MAX : PAYLOAD_W'(total);
                    end else begin
                        payload_left = '0;
                    end
                    pn9_state = PN9_INIT;
                end
                if (header_left != 0) begin
                    header_left--;
                end
            end
            expected_bits.push_back(r);
        endfunction

        // Compare one result with the oldest expected bit
        function void check_bit(t_out_item got);
            t_out_item want;
            if (expected_bits.size() == 0) begin
                report($sformatf("result %b/%b with nothing expected", got.out_bit,
                                 got.whitened));
                return;
            end
            want = expected_bits.pop_front();
            if (got.out_bit !== want.out_bit) begin
                report($sformatf("out_bit expected %b, got %b", want.out_bit, got.out_bit));
            end
            if (got.whitened !== want.whitened) begin
                report($sformatf("whitened expected %b, got %b", want.whitened, got.whitened));
            end
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [HEADER_W-1:0] i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;

    pn9_bit_checker pn9_chk = new();

    bit tx_idle   = 1'b0;
    bit rx_idle   = 1'b0;
    bit hold_req  = 1'b0;
    int sent_bits = 0;
    int cycle_count = 0;

    pn9_packet_dewhitener dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Check results first, then predict from the input transaction of this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                pn9_chk.check_bit(o_out_data);
            end
            if (i_in_valid && !o_in_stall) begin
                pn9_chk.predict_bit(i_in_data);
            end
        end
    end

    // Drive output stall: long hold on request, random bursts, or none
    initial begin
        bit stall_v;
        int stall_n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall_v  = 1'b1;
                stall_n  = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 2) == 0) begin
                stall_v = 1'b1;
                stall_n = $urandom_range(1, 19);
            end else begin
                stall_v = 1'b0;
                stall_n = rx_idle ? $urandom_range(1, 40) : 1;
            end
            i_out_stall <= stall_v;
            repeat (stall_n) @(posedge i_clk);
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_bit(logic b, logic start, logic [BYTES_W-1:0] nbytes);
        t_in_item it;
        it.in_bit       = b;
        it.packet_start = start;
        it.packet_bytes = nbytes;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_bits++;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected bit has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pn9_chk.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_hdr_len(logic [HEADER_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        pn9_chk.hdr_len = value;
    endtask

    // Send whole packets with random content, then a few idle-line bits
    task automatic run_packets(int hb, int min_bits, int max_bytes);
        int first;
        int nbytes;
        int plen;
        first = sent_bits;
        while (sent_bits - first < min_bits) begin
            nbytes = $urandom_range(0, max_bytes);
            plen   = (hb == 0) ? 1 + 8 * nbytes : ((8 * nbytes > hb) ? 8 * nbytes : hb);
            send_bit(1'($urandom_range(0, 1)), 1'b1, BYTES_W'(nbytes));
            // Stray start tags inside the packet must be ignored
            repeat (plen - 1) begin
                send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                         BYTES_W'($urandom_range(0, 2047)));
            end
            repeat ($urandom_range(0, 6)) begin
                send_bit(1'($urandom_range(0, 1)), 1'b0, BYTES_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    task automatic run_phase(int hb, int min_bits, int max_bytes, bit idle_on);
        drain();
        write_hdr_len(HEADER_W'(hb));
        tx_idle = idle_on && ($urandom_range(0, 3) != 0);
        rx_idle = idle_on && ($urandom_range(0, 3) != 0);
        run_packets(hb, min_bits, max_bytes);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle passthrough, header and payload, busy start, short packet
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_hdr_len(16'd2);
        send_bit(1'b0, 1'b0, 11'd2047);
        send_bit(1'b1, 1'b0, 11'd0);
        send_bit(1'b1, 1'b1, 11'd1);
        send_bit(1'b0, 1'b1, 11'd2047);
        send_bit(1'b0, 1'b0, 11'd0);
        send_bit(1'b1, 1'b0, 11'd0);
        send_bit(1'b0, 1'b1, 11'd5);
        send_bit(1'b1, 1'b0, 11'd0);
        send_bit(1'b1, 1'b0, 11'd0);
        send_bit(1'b1, 1'b0, 11'd0);
        // Header longer than packet: zero-length payload
        send_bit(1'b0, 1'b1, 11'd0);
        send_bit(1'b1, 1'b0, 11'd0);
        // No header: start bit copied, full payload follows
        drain();
        write_hdr_len(16'd0);
        send_bit(1'b1, 1'b1, 11'd1);
        repeat (4) send_bit(1'b0, 1'b0, 11'd0);
        repeat (4) send_bit(1'b1, 1'b0, 11'd0);

        // Random packets across header settings
        run_phase(16, 130, 6, 1'b1);
        run_phase(0, 130, 6, 1'b1);
        run_phase(1, 130, 6, 1'b1);
        hold_req = 1'b1;
        run_phase(8, 130, 6, 1'b1);
        run_phase(9, 130, 4, 1'b1);
        run_phase(24, 130, 6, 1'b1);
        repeat (4) run_phase($urandom_range(0, 40), 130, 6, 1'b1);

        // Last part without idling, ending on the largest header and length
        run_phase($urandom_range(0, 12), 120, 4, 1'b0);
        drain();
        write_hdr_len(16'hffff);
        send_bit(1'b1, 1'b1, 11'd2047);
        repeat (40) send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             BYTES_W'($urandom_range(0, 2047)));

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pn9_chk.errors == 0 && pn9_chk.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
